[rtl/packet_reassembly_sequencer_unit_macros.svh]
// assertion macros shared by the packet reassembly sequencer rtl
// no dependencies; included by the modules that carry assertions
`ifndef PACKET_REASSEMBLY_SEQUENCER_UNIT_MACROS_SVH
`define PACKET_REASSEMBLY_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PRSU_ASSERT_IMP(label, msg, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PRSU_ASSERT_NXT(label, msg, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prsu_pkg.sv]
// shared types and constants of the packet reassembly sequencer
// no dependencies; imported by every module of the block
package prsu_pkg;

    localparam int unsigned FIELD_W     = 16;
    localparam int unsigned PROTO_W     = 7;
    localparam int unsigned NUM_PROTO_W = 5;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned STATUS_W    = 4;

    localparam logic [PROTO_W-1:0]     NULL_PROTO    = 7'd127;
    localparam logic [NUM_PROTO_W-1:0] NUM_PROTO_RST = 5'd16;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 4'd0,
        ST_CRC         = 4'd1,
        ST_NULL        = 4'd2,
        ST_BAD_PROTO   = 4'd3,
        ST_SPURIOUS    = 4'd4,
        ST_WRONG_PROTO = 4'd5,
        ST_WRONG_SEQ   = 4'd6,
        ST_WRONG_WIN   = 4'd7,
        ST_EXCESS      = 4'd8
    } t_status;

    // one classified request as it travels from front to back
    typedef struct packed {
        t_status              pre_status;
        logic [PROTO_W-1:0]   protocol;
        logic                 initial_req;
        logic [FIELD_W-1:0]   total_length;
        logic [FIELD_W-1:0]   seq;
        logic [FIELD_W-1:0]   window;
        logic                 packet_first;
        logic                 packet_last;
        logic                 byte_valid;
        logic [BYTE_W-1:0]    payload_byte;
    } t_item;

endpackage

[rtl/packet_reassembly_sequencer_unit.sv]
// Packet reassembly sequencer: checks packet headers and places payload bytes of a message.
// Input channel i_valid/o_stall carries one payload byte per request with its packet header;
// output channel o_valid/i_stall returns exactly one result per request, in order.
// i_cfg_we/i_cfg_data write the protocol count; write it only while the block is idle.
// A request taken into the queue moves on through the read stage register and then the output
// register to o_valid. Throughput: one request per cycle, sustained while nothing stalls.
// The front end classifies headers into a four-deep queue; the back end reads the per-protocol
// sequence table (one read port, written result bypassed) and updates the message state.
// Reset clears message state, the sequence table (valid bits) and both channels, and sets
// the protocol count to 16; the block accepts requests in the first cycle after reset.
// While the receiver stalls, the result holds on the outputs; the queue keeps taking requests
// until it is full, and o_stall rises only then.
// Depends on prsu_pkg, prsu_front, prsu_queue and prsu_back.
module packet_reassembly_sequencer_unit
    import prsu_pkg::*;
#(
    parameter int MAX_PROTOCOLS = 16,
    parameter int SEQ_BITS      = 16,
    parameter int LENGTH_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [NUM_PROTO_W-1:0] i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_crc_ok,
    input  logic [PROTO_W-1:0]     i_protocol,
    input  logic                   i_initial_req,
    input  logic [FIELD_W-1:0]     i_total_length,
    input  logic [FIELD_W-1:0]     i_seq,
    input  logic [FIELD_W-1:0]     i_window,
    input  logic                   i_packet_first,
    input  logic                   i_packet_last,
    input  logic                   i_byte_valid,
    input  logic [BYTE_W-1:0]      i_payload_byte,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_write_valid,
    output logic [FIELD_W-1:0]     o_write_offset,
    output logic [BYTE_W-1:0]      o_write_byte,
    output logic [PROTO_W-1:0]     o_channel,
    output logic                   o_message_done,
    output logic [FIELD_W-1:0]     o_done_length,
    output logic [STATUS_W-1:0]    o_status,
    output logic                   o_seq_resynced,
    output logic                   o_abandoned_incomplete
);

    t_item front_item;
    t_item head_item;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;

    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full;

    prsu_front #(
        .MAX_PROTOCOLS (MAX_PROTOCOLS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_crc_ok       (i_crc_ok),
        .i_protocol     (i_protocol),
        .i_initial_req  (i_initial_req),
        .i_total_length (i_total_length),
        .i_seq          (i_seq),
        .i_window       (i_window),
        .i_packet_first (i_packet_first),
        .i_packet_last  (i_packet_last),
        .i_byte_valid   (i_byte_valid),
        .i_payload_byte (i_payload_byte),
        .o_item         (front_item)
    );

    prsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (head_item),
        .o_empty (q_empty)
    );

    prsu_back #(
        .MAX_PROTOCOLS (MAX_PROTOCOLS),
        .SEQ_BITS      (SEQ_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_head                 (head_item),
        .i_empty                (q_empty),
        .o_pop                  (q_pop),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_write_valid          (o_write_valid),
        .o_write_offset         (o_write_offset),
        .o_write_byte           (o_write_byte),
        .o_channel              (o_channel),
        .o_message_done         (o_message_done),
        .o_done_length          (o_done_length),
        .o_status               (o_status),
        .o_seq_resynced         (o_seq_resynced),
        .o_abandoned_incomplete (o_abandoned_incomplete)
    );

endmodule

[rtl/prsu_front.sv]
// front end: holds the protocol count register and classifies headers
// depends on prsu_pkg
module prsu_front
    import prsu_pkg::*;
#(
    parameter int MAX_PROTOCOLS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [NUM_PROTO_W-1:0] i_cfg_data,
    input  logic                   i_crc_ok,
    input  logic [PROTO_W-1:0]     i_protocol,
    input  logic                   i_initial_req,
    input  logic [FIELD_W-1:0]     i_total_length,
    input  logic [FIELD_W-1:0]     i_seq,
    input  logic [FIELD_W-1:0]     i_window,
    input  logic                   i_packet_first,
    input  logic                   i_packet_last,
    input  logic                   i_byte_valid,
    input  logic [BYTE_W-1:0]      i_payload_byte,
    output t_item                  o_item
);

    logic [NUM_PROTO_W-1:0] r_num_protocols;
    t_status                pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_protocols <= NUM_PROTO_RST;
        end else if (i_cfg_we) begin
            r_num_protocols <= i_cfg_data;
        end
    end

    // checks that need no sequencing state
    always_comb begin
        pre = ST_OK;
        if (!i_crc_ok) begin
            pre = ST_CRC;
        end else if (i_protocol == NULL_PROTO) begin
            pre = ST_NULL;
        end else if (i_protocol >= PROTO_W'(r_num_protocols) ||
                     i_protocol >= PROTO_W'(MAX_PROTOCOLS)) begin
            pre = ST_BAD_PROTO;
        end
    end

    always_comb begin
        o_item.pre_status   = pre;
        o_item.protocol     = i_protocol;
        o_item.initial_req  = i_initial_req;
        o_item.total_length = i_total_length;
        o_item.seq          = i_seq;
        o_item.window       = i_window;
        o_item.packet_first = i_packet_first;
        o_item.packet_last  = i_packet_last;
        o_item.byte_valid   = i_byte_valid;
        o_item.payload_byte = i_payload_byte;
    end

endmodule

[rtl/prsu_queue.sv]
// short request queue between the front end and the sequencing back end
// depends on prsu_pkg and the assertion macro header
`include "packet_reassembly_sequencer_unit_macros.svh"

module prsu_queue
    import prsu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_empty
);

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic [QUEUE_CW-1:0]   n_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `PRSU_ASSERT_IMP(a_queue_bound, "queue count beyond depth", i_clk, i_rst_n, 1'b1, r_count <= QUEUE_CW'(QUEUE_DEPTH))
    `PRSU_ASSERT_NXT(a_queue_grow, "queue count did not grow on push", i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

[rtl/prsu_back.sv]
// back end: sequence table, message state and the output register
// depends on prsu_pkg and the assertion macro header
`include "packet_reassembly_sequencer_unit_macros.svh"

module prsu_back
    import prsu_pkg::*;
#(
    parameter int MAX_PROTOCOLS = 16,
    parameter int SEQ_BITS      = 16,
    parameter int LENGTH_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_write_valid,
    output logic [FIELD_W-1:0]  o_write_offset,
    output logic [BYTE_W-1:0]   o_write_byte,
    output logic [PROTO_W-1:0]  o_channel,
    output logic                o_message_done,
    output logic [FIELD_W-1:0]  o_done_length,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_seq_resynced,
    output logic                o_abandoned_incomplete
);

    localparam int PA = (MAX_PROTOCOLS > 1) ? $clog2(MAX_PROTOCOLS) : 1;
    localparam int CW = (LENGTH_BITS > FIELD_W) ? LENGTH_BITS : FIELD_W;

    // read stage
    logic                   r_b1_vld;
    t_item                  r_b1;
    logic [SEQ_BITS-1:0]    r_seq_mem [MAX_PROTOCOLS];
    logic [MAX_PROTOCOLS-1:0] r_seq_vld;
    logic [SEQ_BITS-1:0]    r_rd_seq;
    logic                   r_rd_vld;
    logic                   r_byp;
    logic [SEQ_BITS-1:0]    r_byp_data;

    // message state
    logic [LENGTH_BITS-1:0] r_fill;
    logic [LENGTH_BITS-1:0] r_target;
    logic [PROTO_W-1:0]     r_chan;
    logic [SEQ_BITS-1:0]    r_cur_seq;
    logic                   r_accepted;

    // output register
    logic                   r_out_vld;
    logic                   r_out_write_valid;
    logic [FIELD_W-1:0]     r_out_write_offset;
    logic [BYTE_W-1:0]      r_out_write_byte;
    logic [PROTO_W-1:0]     r_out_channel;
    logic                   r_out_message_done;
    logic [FIELD_W-1:0]     r_out_done_length;
    t_status                r_out_status;
    logic                   r_out_seq_resynced;
    logic                   r_out_abandoned;

    logic                   out_ready;
    logic                   commit;
    logic                   b1_load;
    logic [PA-1:0]          rd_addr;
    logic                   wr_en;
    logic [PA-1:0]          wr_addr;
    logic [SEQ_BITS-1:0]    wr_data;

    logic [SEQ_BITS-1:0]    seqv;
    logic [LENGTH_BITS-1:0] lenv;
    logic [SEQ_BITS-1:0]    exp_seq;
    t_status                status;
    logic                   resync;
    logic                   abandon;
    logic                   wvalid;
    logic                   done;
    logic                   acc;
    logic [LENGTH_BITS-1:0] f1;
    logic [LENGTH_BITS-1:0] t1;
    logic [PROTO_W-1:0]     c1;
    logic [SEQ_BITS-1:0]    cur1;
    logic [LENGTH_BITS-1:0] n_fill;
    logic [LENGTH_BITS-1:0] n_target;
    logic [PROTO_W-1:0]     n_chan;
    logic                   n_accepted;

    assign out_ready = !r_out_vld || !i_stall;
    assign commit    = r_b1_vld && out_ready;
    assign b1_load   = !r_b1_vld || commit;
    assign o_pop     = b1_load && !i_empty;

    assign rd_addr = (i_head.protocol < PROTO_W'(MAX_PROTOCOLS)) ? i_head.protocol[PA-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
        end else if (b1_load) begin
            r_b1_vld <= !i_empty;
        end
    end

    // table read, with a bypass for the write committed on the same edge
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1       <= i_head;
            r_rd_seq   <= r_seq_mem[rd_addr];
            r_rd_vld   <= r_seq_vld[rd_addr];
            r_byp      <= wr_en && (wr_addr == rd_addr);
            r_byp_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_seq_mem[wr_addr] <= wr_data;
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_vld <= '0;
        end else if (wr_en) begin
            r_seq_vld[wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        seqv     = SEQ_BITS'(r_b1.seq);
        lenv     = LENGTH_BITS'(r_b1.total_length);
        exp_seq  = r_byp ? r_byp_data : (r_rd_vld ? r_rd_seq : '0);
        status   = ST_OK;
        resync   = 1'b0;
        abandon  = 1'b0;
        wvalid   = 1'b0;
        done     = 1'b0;
        f1       = r_fill;
        t1       = r_target;
        c1       = r_chan;
        cur1     = r_cur_seq;
        acc      = r_accepted;

        // header verdict on the first request of a packet
        if (r_b1.packet_first) begin
            if (r_b1.pre_status != ST_OK) begin
                status = r_b1.pre_status;
            end else if (r_b1.initial_req) begin
                abandon = (r_fill != '0);
                c1      = r_b1.protocol;
                f1      = '0;
                t1      = lenv;
                cur1    = seqv;
                resync  = (exp_seq != seqv);
            end else if (r_fill == '0) begin
                status = ST_SPURIOUS;
            end else if (r_chan != r_b1.protocol) begin
                status = ST_WRONG_PROTO;
                f1     = '0;
            end else if (exp_seq != seqv) begin
                status = ST_WRONG_SEQ;
                f1     = '0;
            end else if (CW'(r_fill) != CW'(r_b1.window)) begin
                status = ST_WRONG_WIN;
                f1     = '0;
            end
            acc = (status == ST_OK);
        end

        n_fill   = f1;
        n_target = t1;
        n_chan   = c1;
        if (acc) begin
            if (r_b1.byte_valid) begin
                if (f1 < t1) begin
                    wvalid = 1'b1;
                    n_fill = f1 + 1'b1;
                end else begin
                    status = ST_EXCESS;
                end
            end
            if (r_b1.packet_last && n_fill == t1) begin
                done     = 1'b1;
                n_fill   = '0;
                n_target = '0;
                n_chan   = NULL_PROTO;
            end
        end
        n_accepted = r_b1.packet_last ? 1'b0 : acc;

        // at most one table write per request; completion wins on a combined one
        wr_en   = commit && (resync || (done && c1 < PROTO_W'(MAX_PROTOCOLS)));
        wr_addr = done ? c1[PA-1:0] : r_b1.protocol[PA-1:0];
        wr_data = done ? cur1 + 1'b1 : seqv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_target   <= '0;
            r_chan     <= NULL_PROTO;
            r_accepted <= 1'b0;
        end else if (commit) begin
            r_fill     <= n_fill;
            r_target   <= n_target;
            r_chan     <= n_chan;
            r_accepted <= n_accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_cur_seq <= cur1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_write_valid  <= wvalid;
            r_out_write_offset <= wvalid ? FIELD_W'(f1) : '0;
            r_out_write_byte   <= wvalid ? r_b1.payload_byte : '0;
            r_out_channel      <= c1;
            r_out_message_done <= done;
            r_out_done_length  <= done ? FIELD_W'(t1) : '0;
            r_out_status       <= status;
            r_out_seq_resynced <= resync;
            r_out_abandoned    <= abandon;
        end
    end

    assign o_valid                = r_out_vld;
    assign o_write_valid          = r_out_write_valid;
    assign o_write_offset         = r_out_write_offset;
    assign o_write_byte           = r_out_write_byte;
    assign o_channel              = r_out_channel;
    assign o_message_done         = r_out_message_done;
    assign o_done_length          = r_out_done_length;
    assign o_status               = r_out_status;
    assign o_seq_resynced         = r_out_seq_resynced;
    assign o_abandoned_incomplete = r_out_abandoned;

    `PRSU_ASSERT_IMP(a_fill_in_range, "fill offset beyond message length", i_clk, i_rst_n, 1'b1, r_fill <= r_target)
    `PRSU_ASSERT_IMP(a_open_channel, "message open on an invalid channel", i_clk, i_rst_n, r_fill != '0, r_chan < PROTO_W'(MAX_PROTOCOLS))
    `PRSU_ASSERT_IMP(a_write_status, "byte written with a non-ok status", i_clk, i_rst_n, r_out_vld && r_out_write_valid, r_out_status == ST_OK)

endmodule
